// ----- rtl/core/text_console_writer_core_defines.svh -----
// Assertion macros for the text console writer.
// Assertions are compiled out when SYNTHESIS is defined.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define TCW_ASSERT_NOW(label, clk, rst, ante, cons)
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

  // Command codes carried in the input tuser field.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE    = 8'h0a;
  localparam logic [7:0] RESET_ATTRIBUTE = 8'h0f;
  localparam logic [7:0] BLANK_CHAR      = 8'h00;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CMD_W      = 2;
  localparam int INDEX_W    = 11;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_MOVE,
    ST_FILL,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/text_console_writer_core.sv -----
`timescale 1ns / 1ps

// Text console writer: a COLUMNS by ROWS screen of 16-bit cells (character in the
// low byte, attribute in the high byte) held in one single-port-write, one-read
// synchronous memory, with a cursor. Each input word is one command; each command
// returns exactly one output word carrying the cell read (zero unless reading) and
// the cursor afterwards. A read of a cell on the screen passes through the registered
// memory read and the read state before it reports; a put that does not scroll, a
// read past the screen and any unknown command report straight from the idle state.
// Clear walks the memory one cell per cycle and then reports. A put while the
// cursor stands past the last cell scrolls: the copy moves one cell per cycle
// through the memory read and write ports, the last copied cell is written back,
// and the blank rows are then filled one cell per cycle. After reset the block
// runs a clearing pass over every cell before it accepts its first word; the
// attribute register may be written during that pass.
module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  // Command stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: [7:0] char_code, [18:8] cell_index, [23:19] zero.
  input  logic [tcw_pkg::IN_DATA_W-1:0]   s_tdata,
  // s_tuser: [1:0] command.
  input  logic [tcw_pkg::CMD_W-1:0]       s_tuser,
  // Result stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: [7:0] cell_char, [15:8] cell_attribute, [26:16] cursor_position,
  // [31:27] zero.
  output logic [tcw_pkg::OUT_DATA_W-1:0]  m_tdata,
  // Attribute register write.
  input  logic                            cfg_we,
  input  logic [7:0]                      cfg_wdata
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int COLW  = $clog2(COLUMNS);

  localparam logic [CW-1:0]   CELLS_C     = CW'(CELLS);
  localparam logic [CW-1:0]   LAST_CELL_C = CW'(CELLS - 1);
  localparam logic [CW-1:0]   ROW_C       = CW'(COLUMNS);
  localparam logic [CW-1:0]   TWO_ROWS_C  = CW'(2 * COLUMNS);
  localparam logic [CW-1:0]   LAST_ROW_C  = CW'(CELLS - COLUMNS);
  localparam logic [COLW-1:0] LAST_COL_C  = COLW'(COLUMNS - 1);

  // Input word fields.
  logic [7:0]         in_char;
  logic [INDEX_W-1:0] in_index;
  logic [CMD_W-1:0]   in_cmd;
  logic               in_accept;
  logic               in_range;

  assign in_char   = s_tdata[7:0];
  assign in_index  = s_tdata[8 +: INDEX_W];
  assign in_cmd    = s_tuser;
  assign in_accept = s_tvalid && s_tready;
  assign in_range  = 32'(in_index) < 32'(CELLS);

  // Screen memory: one write and one registered read per cycle.
  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Control and cursor state.
  state_t          state, state_next;
  logic [CW-1:0]   ptr, ptr_next;
  logic [CW-1:0]   shift, shift_next;
  logic            pend, pend_next;
  logic [AW-1:0]   pend_addr, pend_addr_next;
  logic [CW-1:0]   cursor, cursor_next;
  logic [COLW-1:0] col, col_next;
  logic            put_flag, put_flag_next;
  logic [7:0]      put_char, put_char_next;
  logic [7:0]      attr;

  // Result register.
  logic            out_load;
  logic [7:0]      out_char, out_char_next;
  logic [7:0]      out_attr, out_attr_next;
  logic            out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      ptr      <= '0;
      pend     <= 1'b0;
      cursor   <= '0;
      col      <= '0;
      put_flag <= 1'b0;
      attr     <= RESET_ATTRIBUTE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      pend     <= pend_next;
      cursor   <= cursor_next;
      col      <= col_next;
      put_flag <= put_flag_next;
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    shift     <= shift_next;
    pend_addr <= pend_addr_next;
    put_char  <= put_char_next;
    if (out_load) begin
      out_char <= out_char_next;
      out_attr <= out_attr_next;
    end
  end

  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    shift_next     = shift;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    cursor_next    = cursor;
    col_next       = col;
    put_flag_next  = put_flag;
    put_char_next  = put_char;
    mem_we         = 1'b0;
    mem_waddr      = ptr[AW-1:0];
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = AW'(in_index);
    out_load       = 1'b0;
    out_char_next  = '0;
    out_attr_next  = '0;

    case (state)
      ST_INIT, ST_CLEAR: begin
        // Zero one cell per cycle.
        mem_we    = 1'b1;
        mem_waddr = ptr[AW-1:0];
        mem_wdata = '0;
        ptr_next  = ptr + 1'b1;
        if (ptr == LAST_CELL_C) begin
          state_next = (state == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_PUT: begin
              if (cursor == CELLS_C) begin
                // Past the end: scroll before the write lands.
                ptr_next      = '0;
                put_flag_next = (in_char != NEWLINE_CODE);
                put_char_next = in_char;
                col_next      = '0;
                if (in_char == NEWLINE_CODE) begin
                  shift_next  = TWO_ROWS_C;
                  cursor_next = LAST_ROW_C;
                end else begin
                  shift_next  = ROW_C;
                  cursor_next = LAST_ROW_C + 1'b1;
                  col_next    = COLW'(1);
                end
                state_next = ST_MOVE;
              end else if (in_char == NEWLINE_CODE) begin
                cursor_next = cursor - CW'(col) + ROW_C;
                col_next    = '0;
                out_load    = 1'b1;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = cursor[AW-1:0];
                mem_wdata   = {attr, in_char};
                cursor_next = cursor + 1'b1;
                col_next    = (col == LAST_COL_C) ? '0 : col + 1'b1;
                out_load    = 1'b1;
              end
            end
            CMD_CLEAR: begin
              ptr_next      = '0;
              cursor_next   = '0;
              col_next      = '0;
              put_flag_next = 1'b0;
              state_next    = ST_CLEAR;
            end
            CMD_READ: begin
              if (in_range) begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(in_index);
                state_next = ST_READ;
              end else begin
                out_load = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        out_load      = 1'b1;
        out_char_next = rdata[7:0];
        out_attr_next = rdata[15:8];
        state_next    = ST_IDLE;
      end

      ST_MOVE: begin
        // Read the source cell now; the previous read is written back below it.
        mem_re         = 1'b1;
        mem_raddr      = AW'(ptr + shift);
        pend_next      = 1'b1;
        pend_addr_next = ptr[AW-1:0];
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr;
          mem_wdata = rdata;
        end
        ptr_next = ptr + 1'b1;
        if ((ptr + shift) == LAST_CELL_C) begin
          state_next = ST_FILL;
        end
      end

      ST_FILL: begin
        if (pend) begin
          // Last copied cell still owes its write.
          mem_we    = 1'b1;
          mem_waddr = pend_addr;
          mem_wdata = rdata;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = ptr[AW-1:0];
          mem_wdata = {attr, BLANK_CHAR};
          ptr_next  = ptr + 1'b1;
          if (ptr == LAST_CELL_C) begin
            state_next = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (put_flag) begin
          mem_we    = 1'b1;
          mem_waddr = LAST_ROW_C[AW-1:0];
          mem_wdata = {attr, put_char};
        end
        put_flag_next = 1'b0;
        out_load      = 1'b1;
        state_next    = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tdata = {{(OUT_DATA_W - 16 - INDEX_W){1'b0}}, INDEX_W'(cursor), out_attr, out_char};

  `include "text_console_writer_core_defines.svh"

  // A command that takes the block out of the idle state never finds an undelivered result.
  `TCW_ASSERT_NOW(a_busy_out_empty, clk, rst, state != ST_IDLE && state != ST_INIT, !m_tvalid)
  // The cursor never runs beyond the past-end position.
  `TCW_ASSERT_NOW(a_cursor_bound, clk, rst, 1'b1, cursor <= CELLS_C)
  // At the past-end position the column tracker sits at zero.
  `TCW_ASSERT_NOW(a_col_past_end, clk, rst, cursor == CELLS_C, col == '0)
  // A pending copy write is always drained before the blank fill advances.
  `TCW_ASSERT_NEXT(a_fill_order, clk, rst, state == ST_FILL && pend, ptr == $past(ptr))

endmodule

// ----- tb/text_console_writer_checker.sv -----
`timescale 1ns / 1ps

module text_console_writer_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [tcw_pkg::CMD_W-1:0]      s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [tcw_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [7:0]                     cfg_wdata,
  output int                             fail_count,
  output int                             pending_replies
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attribute;
    logic [10:0] cursor_position;
  } console_reply_t;

  // Our own copy of the screen, cursor and attribute register.
  logic [15:0]    screen [CELLS];
  int unsigned    cursor_pos;
  logic [7:0]     attribute;
  console_reply_t expected_replies[$];

  // Moves the screen up by a number of rows and blanks the rows freed at the bottom.
  function automatic void scroll_up(input int unsigned rows);
    int unsigned keep;
    keep = CELLS - rows * COLUMNS;
    for (int unsigned i = 0; i < CELLS; i++) begin
      if (i < keep) begin
        screen[i] = screen[i + rows * COLUMNS];
      end else begin
        screen[i] = {attribute, BLANK_CHAR};
      end
    end
  endfunction

  function automatic console_reply_t predict_reply(input logic [1:0] cmd,
                                                   input logic [7:0] code,
                                                   input logic [10:0] index);
    console_reply_t reply;
    int unsigned    pos;
    reply = '0;
    case (cmd)
      CMD_PUT: begin
        pos = cursor_pos;
        if (pos >= CELLS) begin
          if (code != NEWLINE_CODE) begin
            scroll_up(1);
            pos = CELLS - COLUMNS;
          end else begin
            scroll_up(2);
            pos = CELLS - 2 * COLUMNS;
          end
        end
        if (code == NEWLINE_CODE) begin
          cursor_pos = COLUMNS * (pos / COLUMNS + 1);
        end else begin
          screen[pos] = {attribute, code};
          cursor_pos  = pos + 1;
        end
      end
      CMD_CLEAR: begin
        foreach (screen[i]) screen[i] = '0;
        cursor_pos = 0;
      end
      CMD_READ: begin
        if (index < CELLS) begin
          reply.cell_char      = screen[index][7:0];
          reply.cell_attribute = screen[index][15:8];
        end
      end
      default: begin
      end
    endcase
    reply.cursor_position = cursor_pos[10:0];
    return reply;
  endfunction

  always @(posedge clk) begin
    console_reply_t seen;
    console_reply_t wanted;
    if (rst) begin
      foreach (screen[i]) screen[i] = '0;
      cursor_pos = 0;
      attribute  = RESET_ATTRIBUTE;
      expected_replies.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        attribute = cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        expected_replies.push_back(predict_reply(s_tuser, s_tdata[7:0], s_tdata[18:8]));
      end
      if (m_tvalid && m_tready) begin
        seen = {m_tdata[7:0], m_tdata[15:8], m_tdata[26:16]};
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected result word char %0h attr %0h cursor %0d", $realtime,
                     seen.cell_char, seen.cell_attribute, seen.cursor_position);
          end
        end else begin
          wanted = expected_replies.pop_front();
          if (seen != wanted) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch: char %0h/%0h attr %0h/%0h cursor %0d/%0d (want/got)",
                       $realtime, wanted.cell_char, seen.cell_char, wanted.cell_attribute,
                       seen.cell_attribute, wanted.cursor_position, seen.cursor_position);
            end
          end
        end
      end
    end
    pending_replies = expected_replies.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // The fourth command code does nothing in the block; it is sent as noise.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Words sent in each randomised phase, and the length of the long receiver hold-off.
  localparam int PHASE_WORDS     = 150;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [7:0]            cfg_wdata;

  int fail_count;
  int pending_replies;

  // Sender pacing: words go out in bursts, with an idle gap between bursts, mostly up to
  // max_gap but now and then a longer one. A max_gap of zero gives back-to-back words.
  int burst_left;
  int max_gap;
  int words_sent;

  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit hold_off_request;

  text_console_writer_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // The checker sits beside the block, watching both streams and the register port.
  text_console_writer_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_replies (pending_replies)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offers one command word at a falling edge and holds it until the block takes it.
  // The handshake is sampled at the rising edge, before the block's own updates land.
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] code,
                           input logic [10:0] index);
    int gap;
    if (max_gap > 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, max_gap);
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(IN_DATA_W - 19){1'b0}}, index, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Stops offering words and waits until every result word has come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_replies != 0) @(negedge clk);
  endtask

  // The attribute register is only ever written while the block is idle.
  task automatic set_attribute(input logic [7:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One randomised phase. Most of it is text as a console would see it: short lines
  // ending in a newline, now and then a line long enough to wrap. That walks the
  // cursor to the bottom row and then keeps the screen scrolling, with both the
  // printable and the newline scroll reached. Reads, dead commands and the odd clear
  // are mixed in between the lines.
  task automatic run_phase(input logic [7:0] attr, input int gap_limit, input bit hold_off);
    int kind;
    int len;
    int stop;
    set_attribute(attr);
    max_gap    = gap_limit;
    burst_left = 0;
    if (hold_off) begin
      hold_off_request = 1'b1;
    end
    stop = words_sent + PHASE_WORDS;
    while (words_sent < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(70, 170) : $urandom_range(0, 5);
        repeat (len) begin
          send_word(CMD_PUT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        end
        send_word(CMD_PUT, NEWLINE_CODE, 11'($urandom_range(0, 2047)));
      end else if (kind < 95) begin
        // Reads land anywhere, including past the end of the screen, or in the bottom
        // rows where most of the recent text sits.
        repeat ($urandom_range(1, 4)) begin
          send_word(CMD_READ, 8'($urandom_range(0, 255)),
                    $urandom_range(0, 1) ? 11'($urandom_range(0, 2047))
                                         : 11'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1)));
        end
      end else if (kind < 98) begin
        send_word(CMD_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end else begin
        send_word(CMD_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end
    end
  endtask

  // Receiver: alternates between stretches that are always ready, randomly ready,
  // mostly stalled and toggling. On request it holds off for a long stretch while the
  // sender keeps offering, so the block fills up and stops taking command words.
  initial begin
    int kind;
    int span;
    m_tready = 1'b0;
    forever begin
      kind = $urandom_range(0, 3);
      span = $urandom_range(10, 200);
      repeat (span) begin
        @(negedge clk);
        if (hold_off_request) begin
          hold_off_request = 1'b0;
          m_tready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(negedge clk);
        end
        case (kind)
          0: begin
            m_tready <= 1'b1;
          end
          1: begin
            m_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            m_tready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            m_tready <= ~m_tready;
          end
        endcase
      end
    end
  end

  initial begin
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    s_tuser          = CMD_PUT;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    rst              = 1'b1;
    burst_left       = 0;
    max_gap          = 0;
    words_sent       = 0;
    hold_off_request = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, first with the attribute left at its reset value. The block runs
    // its clearing pass first; the sender simply waits for ready.
    max_gap = 3;
    send_word(CMD_READ, 8'h00, 11'd0);
    send_word(CMD_READ, 8'hff, 11'(CELLS - 1));
    send_word(CMD_READ, 8'h00, 11'(CELLS));    // first index past the screen
    send_word(CMD_READ, 8'h00, 11'h7ff);    // largest index the field can carry
    send_word(CMD_PUT, 8'h00, 11'h7ff);     // character zero is stored like any other
    send_word(CMD_PUT, 8'hff, 11'd0);
    send_word(CMD_PUT, 8'h41, 11'h555);
    send_word(CMD_PUT, NEWLINE_CODE, 11'h2aa);
    send_word(CMD_UNUSED, 8'hff, 11'h7ff);  // dead command only reports the cursor
    send_word(CMD_READ, 8'h00, 11'd0);
    send_word(CMD_READ, 8'h00, 11'd1);
    send_word(CMD_READ, 8'h00, 11'd2);

    // Top attribute value: new text picks it up, old text keeps its own.
    set_attribute(8'hff);
    send_word(CMD_PUT, 8'h55, 11'd0);
    send_word(CMD_PUT, 8'haa, 11'd0);
    send_word(CMD_READ, 8'h00, 11'(COLUMNS));
    send_word(CMD_READ, 8'h00, 11'(COLUMNS + 1));
    send_word(CMD_READ, 8'h00, 11'd1);

    // Clear zeroes attribute bytes too and homes the cursor.
    send_word(CMD_CLEAR, 8'hff, 11'h7ff);
    send_word(CMD_READ, 8'h00, 11'd0);
    send_word(CMD_READ, 8'h00, 11'(COLUMNS));

    set_attribute(8'h00);
    send_word(CMD_PUT, 8'h7e, 11'd0);
    send_word(CMD_PUT, NEWLINE_CODE, 11'd0);
    send_word(CMD_READ, 8'h00, 11'd0);

    // Randomised phases across the attribute range, the first back-to-back with the
    // long receiver hold-off, the rest with sender gaps of varying length.
    run_phase(8'hff, 0, 1'b1);
    run_phase(8'h00, 4, 1'b0);
    run_phase(8'($urandom_range(1, 254)), 2, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8, 1'b0);

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_replies == 0) begin
      $display("text_console_writer_core test passed");
    end else begin
      $display("text_console_writer_core test failed");
    end
    $finish;
  end

  // Watchdog, well beyond a run in which every word scrolls and waits out every stall.
  initial begin
    #200_000_000;
    $display("text_console_writer_core test failed");
    $finish;
  end

endmodule
